>>> rtl/core/rbfi_pkg.sv
package rbfi_pkg;

  // Field and datapath widths
  localparam int CW       = 32;            // coordinate, Q16.16
  localparam int EW       = 31;            // box extent
  localparam int MW       = 3;             // axis mask
  localparam int DW       = CW + 1;        // direction component
  localparam int BW       = CW + 2;        // box bound
  localparam int NUMW     = BW + 1;        // face bound minus start
  localparam int QW       = 33;            // quotient bits produced by the divider
  localparam int RW       = 32;            // divider remainder / divisor
  localparam int PRODW    = 64;            // t magnitude times direction magnitude
  localparam int PW       = 49;            // point on the line before saturation
  localparam int AW       = 5;             // cfg byte address
  localparam int DATAW    = 32;            // cfg data
  localparam int NAXIS    = 3;
  localparam int DIV_SPS  = 3;             // quotient bits per divider stage
  localparam int DIV_ST   = QW / DIV_SPS;  // divider stages
  localparam logic [2:0] LAST_FACE = 3'd5;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_EXTENT_X,
    REG_EXTENT_Y,
    REG_EXTENT_Z,
    REG_AXIS_MASK
  } reg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_z;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] end_z;
  } in_item_t;

  typedef struct packed {
    logic                 hit_valid;
    logic signed [CW-1:0] hit_x;
    logic signed [CW-1:0] hit_y;
    logic signed [CW-1:0] hit_z;
    logic                 last;
  } out_item_t;

  // One face test travelling down the pipe
  typedef struct packed {
    logic                         valid;
    logic                         end_item;
    logic                         tested;
    logic [1:0]                   axis;
    logic                         side;
    logic [NAXIS-1:0][CW-1:0]     p0;
    logic [NAXIS-1:0][DW-1:0]     dir;
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic signed [NUMW-1:0] num;
  } s1_t;

  typedef struct packed {
    op_t           op;
    logic          neg;
    logic          ovf;
    logic [RW-1:0] rem;
    logic [QW-1:0] nlo;
    logic [QW-1:0] quo;
    logic [RW-1:0] dvs;
  } div_t;

  typedef struct packed {
    op_t           op;
    logic [CW-1:0] mt;
    logic          tneg;
    logic          sat;
  } tst_t;

  typedef struct packed {
    op_t                         op;
    logic                        sat;
    logic [NAXIS-1:0][PRODW-1:0] prod;
    logic [NAXIS-1:0]            pneg;
  } mul_t;

  typedef struct packed {
    op_t                      op;
    logic [NAXIS-1:0][PW-1:0] pt;
  } add_t;

  typedef struct packed {
    op_t                      op;
    logic                     hit;
    logic [NAXIS-1:0][CW-1:0] coord;
  } cmp_t;

  // One restoring division step: one quotient bit
  function automatic div_t div_step(div_t s);
    div_t        o;
    logic [RW:0] r2;
    o     = s;
    r2    = {s.rem, s.nlo[QW-1]};
    o.nlo = {s.nlo[QW-2:0], 1'b0};
    if (r2 >= {1'b0, s.dvs}) begin
      o.rem = RW'(r2 - {1'b0, s.dvs});
      o.quo = {s.quo[QW-2:0], 1'b1};
    end else begin
      o.rem = r2[RW-1:0];
      o.quo = {s.quo[QW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

>>> rtl/core/ray_box_face_intersect_core.sv
// Line / axis-aligned box face intersection, Q16.16.
// Input channel (in_valid/in_ready/in_data): one segment per transfer, start and
// end point. Result channel (out_valid/out_ready/out_data): one transfer per hit
// point in face order x-min, x-max, y-min, y-max, z-min, z-max, or a single
// no-hit transfer; last marks the final transfer of each segment.
// The user must set box and axis mask through the cfg_ APB port only while the
// block is idle; the block does not enforce it. The issue stage walks the six
// faces of a segment, one face a cycle into the single shared divider pipe
// unless the pipe stalls, and takes the next segment with the last face. A
// result passes the issue, bound, 11 divider stages, t, multiply, add, compare
// and output registers; a hit waits in the collect register until the next hit
// or the segment end shows whether it is last. Reset clears the configuration
// registers to zero and empties the pipeline. When a result waits in the output
// register and the receiver stalls, the whole pipe holds and in_ready drops.
module ray_box_face_intersect_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rbfi_pkg::in_item_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rbfi_pkg::out_item_t       out_data,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [rbfi_pkg::AW-1:0]   cfg_paddr,
  input  logic [rbfi_pkg::DATAW-1:0] cfg_pwdata,
  output logic [rbfi_pkg::DATAW-1:0] cfg_prdata,
  output logic                      cfg_pready
);
  import rbfi_pkg::*;

  // Configuration registers
  logic signed [CW-1:0] ctr_r [NAXIS];
  logic [EW-1:0]        ext_r [NAXIS];
  logic [MW-1:0]        mask_r;
  reg_idx_t             cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NAXIS; a++) begin
        ctr_r[a] <= '0;
        ext_r[a] <= '0;
      end
      mask_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_idx)
        REG_CENTER_X:  ctr_r[0] <= cfg_pwdata[CW-1:0];
        REG_CENTER_Y:  ctr_r[1] <= cfg_pwdata[CW-1:0];
        REG_CENTER_Z:  ctr_r[2] <= cfg_pwdata[CW-1:0];
        REG_EXTENT_X:  ext_r[0] <= cfg_pwdata[EW-1:0];
        REG_EXTENT_Y:  ext_r[1] <= cfg_pwdata[EW-1:0];
        REG_EXTENT_Z:  ext_r[2] <= cfg_pwdata[EW-1:0];
        REG_AXIS_MASK: mask_r   <= cfg_pwdata[MW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      REG_CENTER_X:  cfg_prdata = ctr_r[0];
      REG_CENTER_Y:  cfg_prdata = ctr_r[1];
      REG_CENTER_Z:  cfg_prdata = ctr_r[2];
      REG_EXTENT_X:  cfg_prdata = DATAW'(ext_r[0]);
      REG_EXTENT_Y:  cfg_prdata = DATAW'(ext_r[1]);
      REG_EXTENT_Z:  cfg_prdata = DATAW'(ext_r[2]);
      REG_AXIS_MASK: cfg_prdata = DATAW'(mask_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // Box bounds, min = centre - floor(extent/2), max = centre + floor(extent/2)
  logic signed [BW-1:0] bmin_r [NAXIS];
  logic signed [BW-1:0] bmax_r [NAXIS];

  always_ff @(posedge clk) begin
    for (int a = 0; a < NAXIS; a++) begin
      bmin_r[a] <= {{2{ctr_r[a][CW-1]}}, ctr_r[a]} - {3'b000, ext_r[a][EW-1:1]};
      bmax_r[a] <= {{2{ctr_r[a][CW-1]}}, ctr_r[a]} + {3'b000, ext_r[a][EW-1:1]};
    end
  end

  // Pipeline advance: everything moves when the output register can load
  logic      en;
  logic      out_valid_r;
  out_item_t out_data_r;

  assign en        = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Issue stage: holds one segment, walks the six faces
  logic                     iss_valid_r;
  logic [2:0]               face_r;
  logic [NAXIS-1:0][CW-1:0] iss_p0_r;
  logic [NAXIS-1:0][DW-1:0] iss_dir_r;
  logic [NAXIS-1:0][CW-1:0] in_s;
  logic [NAXIS-1:0][CW-1:0] in_e;

  assign in_ready = en && (!iss_valid_r || face_r == LAST_FACE);

  // disabled axes are cleared before the direction is formed
  always_comb begin
    in_s[0] = in_data.start_x;
    in_s[1] = in_data.start_y;
    in_s[2] = in_data.start_z;
    in_e[0] = in_data.end_x;
    in_e[1] = in_data.end_y;
    in_e[2] = in_data.end_z;
    for (int a = 0; a < NAXIS; a++) begin
      if (!mask_r[a]) begin
        in_s[a] = '0;
        in_e[a] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_valid_r <= 1'b0;
      face_r      <= '0;
    end else if (en) begin
      if (!iss_valid_r || face_r == LAST_FACE) begin
        iss_valid_r <= in_valid;
        face_r      <= '0;
      end else begin
        face_r <= face_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      for (int a = 0; a < NAXIS; a++) begin
        iss_p0_r[a]  <= in_s[a];
        iss_dir_r[a] <= {in_e[a][CW-1], in_e[a]} - {in_s[a][CW-1], in_s[a]};
      end
    end
  end

  // Stage 1: face selection and numerator bound - start
  s1_t                  s1_nxt, s1_r;
  logic [1:0]           iss_axis;
  logic signed [BW-1:0] iss_bnd;

  always_comb begin
    iss_axis           = face_r[2:1];
    iss_bnd            = face_r[0] ? bmax_r[iss_axis] : bmin_r[iss_axis];
    s1_nxt.op.valid    = iss_valid_r;
    s1_nxt.op.end_item = (face_r == LAST_FACE);
    s1_nxt.op.tested   = (iss_dir_r[iss_axis] != '0);
    s1_nxt.op.axis     = iss_axis;
    s1_nxt.op.side     = face_r[0];
    s1_nxt.op.p0       = iss_p0_r;
    s1_nxt.op.dir      = iss_dir_r;
    s1_nxt.num         = {iss_bnd[BW-1], iss_bnd}
                       - {{(NUMW-CW){iss_p0_r[iss_axis][CW-1]}}, iss_p0_r[iss_axis]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_r.op.valid <= 1'b0;
    else if (en) s1_r <= s1_nxt;
  end

  // Divider: t = (num * 2^16) / dir, unsigned magnitudes, DIV_SPS bits a stage
  div_t              div_init;
  div_t              div_nxt [DIV_ST];
  div_t              div_r   [DIV_ST];
  logic [NUMW-1:0]   s1_nabs;
  logic [DW-1:0]     s1_dv;
  logic [DW-1:0]     s1_dabs;

  always_comb begin
    s1_nabs       = s1_r.num[NUMW-1] ? NUMW'(-s1_r.num) : NUMW'(s1_r.num);
    s1_dv         = s1_r.op.dir[s1_r.op.axis];
    s1_dabs       = s1_dv[DW-1] ? DW'(-s1_dv) : s1_dv;
    div_init.op   = s1_r.op;
    div_init.neg  = s1_r.num[NUMW-1] ^ s1_dv[DW-1];
    div_init.dvs  = s1_dabs[RW-1:0];
    div_init.rem  = RW'(s1_nabs[QW-1:17]);
    div_init.ovf  = RW'(s1_nabs[QW-1:17]) >= s1_dabs[RW-1:0];
    div_init.nlo  = {s1_nabs[16:0], 16'h0000};
    div_init.quo  = '0;
    div_nxt[0] = div_init;
    for (int i = 0; i < DIV_SPS; i++) div_nxt[0] = div_step(div_nxt[0]);
    for (int j = 1; j < DIV_ST; j++) begin
      div_nxt[j] = div_r[j-1];
      for (int i = 0; i < DIV_SPS; i++) div_nxt[j] = div_step(div_nxt[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DIV_ST; j++) div_r[j].op.valid <= 1'b0;
    end else if (en) begin
      for (int j = 0; j < DIV_ST; j++) div_r[j] <= div_nxt[j];
    end
  end

  // t stage: saturate quotient to signed 32 bits
  tst_t          t_nxt, t_r;
  logic [QW-1:0] q_last;

  always_comb begin
    q_last    = div_r[DIV_ST-1].quo;
    t_nxt.op  = div_r[DIV_ST-1].op;
    t_nxt.tneg = div_r[DIV_ST-1].neg;
    t_nxt.sat = div_r[DIV_ST-1].ovf
              || (div_r[DIV_ST-1].neg  && q_last > QW'(33'h0_8000_0000))
              || (!div_r[DIV_ST-1].neg && q_last > QW'(33'h0_7FFF_FFFF));
    if (t_nxt.sat) t_nxt.mt = div_r[DIV_ST-1].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else           t_nxt.mt = q_last[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) t_r.op.valid <= 1'b0;
    else if (en) t_r <= t_nxt;
  end

  // Multiply stage: |t| * |dir| per axis
  mul_t          mul_nxt, mul_r;
  logic [DW-1:0] m_dabs [NAXIS];

  always_comb begin
    mul_nxt.op  = t_r.op;
    mul_nxt.sat = t_r.sat;
    for (int k = 0; k < NAXIS; k++) begin
      m_dabs[k] = t_r.op.dir[k][DW-1] ? DW'(-t_r.op.dir[k]) : t_r.op.dir[k];
      mul_nxt.prod[k] = t_r.mt * m_dabs[k][RW-1:0];
      mul_nxt.pneg[k] = t_r.tneg ^ t_r.op.dir[k][DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mul_r.op.valid <= 1'b0;
    else if (en) mul_r <= mul_nxt;
  end

  // Add stage: p = start + trunc(t*d / 2^16); exact bound on the face axis unless t saturated
  add_t                 add_nxt, add_r;
  logic [PW-1:0]        a_off [NAXIS];
  logic signed [BW-1:0] a_bnd;

  always_comb begin
    add_nxt.op = mul_r.op;
    a_bnd = mul_r.op.side ? bmax_r[mul_r.op.axis] : bmin_r[mul_r.op.axis];
    for (int k = 0; k < NAXIS; k++) begin
      a_off[k] = {1'b0, mul_r.prod[k][PRODW-1:16]};
      if (mul_r.pneg[k]) a_off[k] = PW'(-a_off[k]);
      add_nxt.pt[k] = {{(PW-CW){mul_r.op.p0[k][CW-1]}}, mul_r.op.p0[k]} + a_off[k];
      if (k == int'(mul_r.op.axis) && !mul_r.sat)
        add_nxt.pt[k] = {{(PW-BW){a_bnd[BW-1]}}, a_bnd};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) add_r.op.valid <= 1'b0;
    else if (en) add_r <= add_nxt;
  end

  // Compare stage: inclusive inside test, saturate to coordinate width
  cmp_t cmp_nxt, cmp_r;
  logic c_in;

  always_comb begin
    cmp_nxt.op = add_r.op;
    c_in = 1'b1;
    for (int k = 0; k < NAXIS; k++) begin
      if ($signed(add_r.pt[k]) < $signed({{(PW-BW){bmin_r[k][BW-1]}}, bmin_r[k]})
          || $signed(add_r.pt[k]) > $signed({{(PW-BW){bmax_r[k][BW-1]}}, bmax_r[k]}))
        c_in = 1'b0;
      if ((&add_r.pt[k][PW-1:CW-1]) || !(|add_r.pt[k][PW-1:CW-1]))
        cmp_nxt.coord[k] = add_r.pt[k][CW-1:0];
      else
        cmp_nxt.coord[k] = add_r.pt[k][PW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    cmp_nxt.hit = add_r.op.valid && add_r.op.tested && c_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cmp_r.op.valid <= 1'b0;
    else if (en) cmp_r <= cmp_nxt;
  end

  // Collector: one hit held back until the next hit or the segment end tells
  // whether it is the last one; a closed record leaves on the next slot
  logic      pend_valid_r, pend_valid_nxt;
  out_item_t pend_r, pend_nxt;
  logic      emit;
  out_item_t emit_item;
  out_item_t new_rec;
  out_item_t nohit_rec;
  logic      ev_end;

  always_comb begin
    ev_end            = cmp_r.op.valid && cmp_r.op.end_item;
    new_rec.hit_valid = 1'b1;
    new_rec.hit_x     = cmp_r.coord[0];
    new_rec.hit_y     = cmp_r.coord[1];
    new_rec.hit_z     = cmp_r.coord[2];
    new_rec.last      = ev_end;
    nohit_rec         = '0;
    nohit_rec.last    = 1'b1;
    emit              = 1'b0;
    emit_item         = pend_r;
    pend_valid_nxt    = pend_valid_r;
    pend_nxt          = pend_r;
    if (pend_valid_r && pend_r.last) begin
      // closed record from the previous segment
      emit           = 1'b1;
      pend_valid_nxt = 1'b0;
      if (cmp_r.hit) begin
        pend_valid_nxt = 1'b1;
        pend_nxt       = new_rec;
      end else if (ev_end) begin
        pend_valid_nxt = 1'b1;
        pend_nxt       = nohit_rec;
      end
    end else if (pend_valid_r) begin
      if (cmp_r.hit) begin
        emit     = 1'b1;
        pend_nxt = new_rec;
      end else if (ev_end) begin
        emit           = 1'b1;
        emit_item.last = 1'b1;
        pend_valid_nxt = 1'b0;
      end
    end else begin
      if (cmp_r.hit) begin
        pend_valid_nxt = 1'b1;
        pend_nxt       = new_rec;
      end else if (ev_end) begin
        emit      = 1'b1;
        emit_item = nohit_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else if (en) begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pend_r     <= pend_nxt;
      out_data_r <= emit_item;
    end
  end

  // Checks
  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    face_r <= LAST_FACE)
    else $error("face counter beyond last face");

  a_nohit_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.hit_valid |->
      out_data_r.last && out_data_r.hit_x == '0 && out_data_r.hit_y == '0
      && out_data_r.hit_z == '0)
    else $error("no-hit transfer malformed");

  a_untested: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_r.op.valid && !cmp_r.op.tested |-> !cmp_r.hit)
    else $error("hit on a face with zero direction");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(t_r) && $stable(pend_valid_r) && $stable(face_r))
    else $error("pipeline moved during stall");

  a_open_pend: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r && !pend_r.last |-> pend_r.hit_valid)
    else $error("open pending record without a hit");

endmodule

>>> sim/tb_ray_box_face_intersect_core.sv
`timescale 1ns / 100ps

module tb_ray_box_face_intersect_core;
  import rbfi_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [AW-1:0] cfg_paddr;
  logic [DATAW-1:0] cfg_pwdata;
  logic [DATAW-1:0] cfg_prdata;
  logic cfg_pready;

  ray_box_face_intersect_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Box as the block holds it
  longint box_ctr[3];
  longint box_ext[3];
  logic [2:0] box_mask;

  in_item_t segment_q[$];
  out_item_t hit_q[$];
  int errors;
  bit gaps_on;
  int send_gap;
  int recv_stall;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  // trunc(t * d / 2^16), split to stay inside 64 bits
  function automatic longint scale_q16(longint t, longint d);
    longint unsigned mt, md, mag;
    mt = (t < 0) ? -t : t;
    md = (d < 0) ? -d : d;
    mag = mt * (md >> 16) + ((mt * (md & 64'hFFFF)) >> 16);
    return ((t < 0) != (d < 0)) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > Q_MAX) return 32'sh7FFFFFFF;
    if (v < Q_MIN) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Work out the hit points of one segment against the current box
  task automatic predict_hits(in_item_t it);
    longint lo[3], hi[3], p0[3], d[3], st[3], en[3], pt[3];
    longint half, bound, num, q;
    bit sat, in_box;
    out_item_t r;
    out_item_t hits[$];
    st[0] = $signed(it.start_x); st[1] = $signed(it.start_y);
    st[2] = $signed(it.start_z);
    en[0] = $signed(it.end_x); en[1] = $signed(it.end_y); en[2] = $signed(it.end_z);
    for (int a = 0; a < 3; a++) begin
      half = box_ext[a] >>> 1;
      lo[a] = box_ctr[a] - half;
      hi[a] = box_ctr[a] + half;
      p0[a] = box_mask[a] ? st[a] : 0;
      d[a] = box_mask[a] ? en[a] - st[a] : 0;
    end
    for (int a = 0; a < 3; a++) begin
      if (d[a] != 0) begin
        for (int f = 0; f < 2; f++) begin
          bound = f ? hi[a] : lo[a];
          num = bound - p0[a];
          q = (num * 65536) / d[a];
          sat = 1'b0;
          if (q > Q_MAX) begin q = Q_MAX; sat = 1'b1; end
          if (q < Q_MIN) begin q = Q_MIN; sat = 1'b1; end
          in_box = 1'b1;
          for (int k = 0; k < 3; k++) begin
            pt[k] = p0[k] + scale_q16(q, d[k]);
            if (k == a && !sat) pt[k] = bound;
            if (pt[k] < lo[k] || pt[k] > hi[k]) in_box = 1'b0;
          end
          if (in_box) begin
            r.hit_valid = 1'b1;
            r.hit_x = clamp32(pt[0]);
            r.hit_y = clamp32(pt[1]);
            r.hit_z = clamp32(pt[2]);
            r.last = 1'b0;
            hits.push_back(r);
          end
        end
      end
    end
    if (hits.size() == 0) begin
      r = '0;
      r.last = 1'b1;
      hits.push_back(r);
    end
    hits[hits.size()-1].last = 1'b1;
    foreach (hits[i]) hit_q.push_back(hits[i]);
  endtask

  // Sender: predicts each transfer, then presents the next pending segment
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) predict_hits(in_data);
      if (in_valid && gaps_on && $urandom_range(0, 1)) begin
        send_gap <= $urandom_range(0, 3);
        in_valid <= 1'b0;
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (segment_q.size() > 0) begin
        in_data <= segment_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls when gaps are on, compare each transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (hit_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
          errors++;
        end else begin
          out_item_t exp_r;
          exp_r = hit_q.pop_front();
          if (out_data.hit_valid !== exp_r.hit_valid || out_data.hit_x !== exp_r.hit_x ||
              out_data.hit_y !== exp_r.hit_y || out_data.hit_z !== exp_r.hit_z ||
              out_data.last !== exp_r.last) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, exp_r, out_data);
            errors++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 2) == 0) begin
        recv_stall <= $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= AW'(int'(idx) * 4);
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_CENTER_X: box_ctr[0] = longint'($signed(val));
      REG_CENTER_Y: box_ctr[1] = longint'($signed(val));
      REG_CENTER_Z: box_ctr[2] = longint'($signed(val));
      REG_EXTENT_X: box_ext[0] = val[30:0];
      REG_EXTENT_Y: box_ext[1] = val[30:0];
      REG_EXTENT_Z: box_ext[2] = val[30:0];
      default: box_mask = val[2:0];
    endcase
  endtask

  task automatic set_box(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                         logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
                         logic [2:0] m);
    reg_write(REG_CENTER_X, cx);
    reg_write(REG_CENTER_Y, cy);
    reg_write(REG_CENTER_Z, cz);
    reg_write(REG_EXTENT_X, ex);
    reg_write(REG_EXTENT_Y, ey);
    reg_write(REG_EXTENT_Z, ez);
    reg_write(REG_AXIS_MASK, {29'd0, m});
  endtask

  // Hold off until every segment is sent and every result has come back
  task automatic drain();
    while (segment_q.size() > 0 || in_valid || hit_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic push_seg(longint sx, longint sy, longint sz,
                          longint ex, longint ey, longint ez);
    in_item_t it;
    it.start_x = sx[31:0]; it.start_y = sy[31:0]; it.start_z = sz[31:0];
    it.end_x = ex[31:0]; it.end_y = ey[31:0]; it.end_z = ez[31:0];
    segment_q.push_back(it);
  endtask

  // Coordinate near the box on one axis, with some full-range noise
  function automatic longint near_box(int a);
    longint span;
    span = box_ext[a] / 2 + box_ext[a] / 4 + 1;
    case ($urandom_range(0, 9))
      0: return longint'($signed($urandom()));
      1: return ($urandom_range(0, 1)) ? Q_MAX : Q_MIN;
      2: return box_ctr[a] + (($urandom_range(0, 1)) ? box_ext[a] / 2 : -(box_ext[a] / 2));
      default: return box_ctr[a] + longint'($urandom_range(0, 65535)) * span / 32768 - span;
    endcase
  endfunction

  initial begin
    logic [31:0] c[3], e[3];
    rst_n = 1'b0;
    gaps_on = 1'b0;
    errors = 0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    for (int a = 0; a < 3; a++) begin
      box_ctr[a] = 0;
      box_ext[a] = 0;
    end
    box_mask = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset box and zero mask: only the no-hit result
    push_seg(1, 2, 3, Q_MAX, Q_MIN, -5);
    push_seg(0, 0, 0, 0, 0, 0);
    drain();

    // Unit box of size 2.0 at the origin, all axes
    set_box(0, 0, 0, 32'h20000, 32'h20000, 32'h20000, 3'b111);
    push_seg(-32'sh30000, 0, 0, 32'sh30000, 0, 0);
    push_seg(0, -32'sh30000, 0, 0, 32'sh30000, 0);
    push_seg(0, 0, -32'sh30000, 0, 0, 32'sh30000);
    push_seg(-32'sh20000, -32'sh20000, -32'sh20000, 32'sh20000, 32'sh20000, 32'sh20000);
    push_seg(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
    push_seg(Q_MIN, 0, Q_MAX, Q_MAX, 1, Q_MIN);
    push_seg(32'sh10000, 32'sh10000, 0, 32'sh10000, 32'sh10000, 0);
    push_seg(32'sh10000, 0, 0, 32'sh10001, 0, 0);
    push_seg(0, 0, 0, 1, 0, 0);
    push_seg(32'sh50000, 32'sh50000, 0, 32'sh60000, 32'sh50001, 0);
    push_seg(-1, -1, -1, -1, -1, -1);
    drain();

    // Zero-size box and extreme extents
    set_box(32'h10000, 32'hFFFF0000, 0, 0, 0, 0, 3'b011);
    push_seg(0, -32'sh10000, 5, 32'sh20000, -32'sh10000, 9);
    push_seg(32'sh10000, 0, 0, 32'sh10000, -32'sh20000, 0);
    drain();
    set_box(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
            32'h7FFFFFFF, 3'b101);
    push_seg(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
    push_seg(0, 0, 0, 7, 0, -3);
    push_seg(Q_MAX, 0, 0, Q_MAX, 0, Q_MIN);
    drain();

    // Random boxes; each mask value in turn, idle gaps on most phases
    for (int ph = 0; ph < 8; ph++) begin
      for (int a = 0; a < 3; a++) begin
        case ($urandom_range(0, 4))
          0: c[a] = $urandom();
          1: c[a] = ($urandom_range(0, 1)) ? 32'h7FFFFFFF : 32'h80000000;
          default: c[a] = $urandom_range(0, 32'h3FFFF) - 32'h20000;
        endcase
        case ($urandom_range(0, 4))
          0: e[a] = $urandom() & 32'h7FFFFFFF;
          1: e[a] = ($urandom_range(0, 1)) ? 32'h7FFFFFFF : 32'h0;
          default: e[a] = $urandom_range(1, 32'h80000);
        endcase
      end
      set_box(c[0], c[1], c[2], e[0], e[1], e[2], ph[2:0]);
      gaps_on = (ph % 3) != 2;
      for (int n = 0; n < 44; n++) begin
        push_seg(near_box(0), near_box(1), near_box(2),
                 near_box(0), near_box(1), near_box(2));
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
